@@ rtl/core/mwo_pkg.sv @@
// Shared types, codes, constants and sine table builder for the oscillator.
package mwo_pkg;

    // Default sizes handed to the top level
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    // Fixed field widths
    localparam int STEP_BITS     = 32;
    localparam int GAIN_BITS     = 16;
    localparam int WAVE_BITS     = 3;
    localparam int OUT_BITS      = 16;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WAVEFORM   = 2'd2;

    // Waveform codes
    localparam logic [WAVE_BITS-1:0] WAVE_SILENT   = 3'd0;
    localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd1;
    localparam logic [WAVE_BITS-1:0] WAVE_SAW      = 3'd2;
    localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd3;
    localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd4;

    // Register reset values
    localparam logic [STEP_BITS-1:0] PHASE_STEP_RST = 32'd0;
    localparam logic [GAIN_BITS-1:0] LEVEL_RST      = 16'd32768;
    localparam logic [WAVE_BITS-1:0] WAVEFORM_RST   = WAVE_SINE;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    // Input and output transactions
    typedef struct packed {
        logic [GAIN_BITS-1:0] envelope;
        logic                 block_end;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sample_out;
        logic                       block_end_out;
    } out_item_t;

    // Job info carried from front to back (phase travels beside it)
    typedef struct packed {
        logic [WAVE_BITS-1:0] waveform;
        logic [GAIN_BITS-1:0] envelope;
        logic                 block_end;
    } job_t;

    // Back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOOKUP,
        BK_SHAPE,
        BK_MUL_ENV,
        BK_MUL_LVL
    } back_state_t;

    // Fixed-point sine table constants, Q30
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // One quarter-wave entry; evaluated at elaboration with constant arguments
    function automatic logic [63:0] mwo_quarter_sine(input int k, input int tb, input int sb);
        logic [63:0] amp;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        int          i;
        amp = (64'd1 << (sb - 1)) - 64'd1;
        x   = (64'(k) * HALF_PI_Q30) >> (tb - 2);
        x2  = (x * x) >> 30;
        t   = ONE_Q30;
        // nested Taylor series
        for (i = 0; i < 6; i++)
            t = ONE_Q30 - (((x2 * t) >> 30) / TAYLOR_DIV[i]);
        s = (x * t) >> 30;
        v = (s * amp + (64'd1 << 29)) >> 30;
        if (v > amp)
            v = amp;
        return v;
    endfunction

endpackage

@@ rtl/core/multi_waveform_oscillator.sv @@
// Phase-accumulator oscillator top level: front end, job queue and back end.
//
// Usage: each input transaction carries one envelope gain and a block-end
// marker; each gives exactly one output transaction with the sample and the
// copied marker. Both channels use valid/ready. phase_step, level and
// waveform are written through cfg_wr_en/cfg_index/cfg_data while idle.
// The back-end sequencer handles one sample at a time and takes no new job
// until the last has reached the output register: table read, shaping,
// envelope multiply, level multiply with saturation, then return to idle
// to fetch the next job.
// The front end keeps accepting until the 2-entry job queue is full, so
// input and output stall independently. The phase advances at acceptance
// for sine, saw, square and triangle; silent and unknown codes hold it.
// Reset clears the phase, the queue and the output valid flag, and returns
// the registers to step 0, level 0.5 and sine. While the receiver stalls,
// the finished sample holds in the output register and the back end waits
// with the next sample ready; the queue then fills and in_ready drops.
module multi_waveform_oscillator #(
    parameter int PHASE_BITS      = mwo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = mwo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mwo_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mwo_pkg::out_item_t                out_item,
    input  logic                              cfg_wr_en,
    input  logic [mwo_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mwo_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import mwo_pkg::*;

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_not_empty;
    logic [PHASE_BITS-1:0] push_phase;
    logic [PHASE_BITS-1:0] head_phase;
    job_t                  push_job;
    job_t                  head_job;
    logic [GAIN_BITS-1:0]  level;

    // Accept, configure, accumulate phase
    mwo_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_phase   (push_phase),
        .q_job     (push_job),
        .level     (level)
    );

    // Job queue
    mwo_queue #(
        .PHASE_BITS (PHASE_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_phase (push_phase),
        .push_job   (push_job),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head_phase (head_phase),
        .head_job   (head_job)
    );

    // Shape, scale and deliver
    mwo_back #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_phase     (head_phase),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .level       (level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule

@@ rtl/core/mwo_queue.sv @@
// Short FIFO between the front end and the back end.
module mwo_queue #(
    parameter int PHASE_BITS = mwo_pkg::PHASE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [PHASE_BITS-1:0] push_phase,
    input  mwo_pkg::job_t         push_job,
    input  logic                  pop,
    output logic                  full,
    output logic                  not_empty,
    output logic [PHASE_BITS-1:0] head_phase,
    output mwo_pkg::job_t         head_job
);
    import mwo_pkg::*;

    logic [PHASE_BITS-1:0] phase_mem [QUEUE_DEPTH];
    job_t                  job_mem   [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg;
    logic [QPTR_BITS-1:0]  rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;
    assign head_phase = phase_mem[rd_ptr_reg];
    assign head_job   = job_mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            phase_mem[wr_ptr_reg] <= push_phase;
            job_mem[wr_ptr_reg]   <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ rtl/core/mwo_front.sv @@
// Front end: configuration registers, input acceptance and phase accumulator.
module mwo_front #(
    parameter int PHASE_BITS = mwo_pkg::PHASE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  mwo_pkg::in_item_t                    in_item,
    input  logic                                 cfg_wr_en,
    input  logic [mwo_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [mwo_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 q_full,
    output logic                                 q_push,
    output logic [PHASE_BITS-1:0]                q_phase,
    output mwo_pkg::job_t                        q_job,
    output logic [mwo_pkg::GAIN_BITS-1:0]        level
);
    import mwo_pkg::*;

    logic [STEP_BITS-1:0]  phase_step_reg;
    logic [GAIN_BITS-1:0]  level_reg;
    logic [WAVE_BITS-1:0]  waveform_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic                  accept;
    logic                  wave_active;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign level    = level_reg;

    // Only the four real waveforms advance the phase
    assign wave_active = (waveform_reg == WAVE_SINE) || (waveform_reg == WAVE_SAW) ||
                         (waveform_reg == WAVE_SQUARE) || (waveform_reg == WAVE_TRIANGLE);

    assign phase_next = phase_reg + PHASE_BITS'(phase_step_reg);

    // Job handed to the back end: phase before this sample's advance
    assign q_push             = accept;
    assign q_phase            = phase_reg;
    assign q_job.waveform     = waveform_reg;
    assign q_job.envelope     = in_item.envelope;
    assign q_job.block_end    = in_item.block_end;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RST;
            level_reg      <= LEVEL_RST;
            waveform_reg   <= WAVEFORM_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PHASE_STEP: phase_step_reg <= cfg_data[STEP_BITS-1:0];
                REG_LEVEL:      level_reg      <= cfg_data[GAIN_BITS-1:0];
                REG_WAVEFORM:   waveform_reg   <= cfg_data[WAVE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Phase accumulator, wraps modulo one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (accept && wave_active)
            phase_reg <= phase_next;
    end

endmodule

@@ rtl/core/mwo_back.sv @@
// Back end: waveform shaping, gain multiplies, saturation and output register.
module mwo_back #(
    parameter int PHASE_BITS      = mwo_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEF,
    parameter int SAMPLE_BITS     = mwo_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_not_empty,
    input  logic [PHASE_BITS-1:0]         q_phase,
    input  mwo_pkg::job_t                 q_job,
    output logic                          q_pop,
    input  logic [mwo_pkg::GAIN_BITS-1:0] level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mwo_pkg::out_item_t            out_item
);
    import mwo_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int TB     = SINE_TABLE_BITS;
    localparam int QLEN   = 1 << (TB - 2);
    localparam int P1_W   = SB + GAIN_BITS;
    localparam int P2_W   = P1_W + GAIN_BITS;
    localparam logic [SB:0]   HALF   = (SB + 1)'(1) << (SB - 1);
    localparam logic [TB-2:0] QLEN_A = (TB - 1)'(QLEN);
    localparam logic signed [OUT_BITS-1:0] SAT_POS = 16'sh7FFF;
    localparam logic signed [OUT_BITS-1:0] SAT_NEG = 16'sh8000;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [PHASE_BITS-1:0] ph_reg;
    job_t                  job_reg;
    logic [SB-2:0]         rom_q_reg;
    logic                  neg_reg;
    logic                  neg_next;
    logic [SB-1:0]         mag_reg;
    logic [SB-1:0]         mag_next;
    logic [P1_W-1:0]       p1_reg;
    out_item_t             out_item_reg;
    out_item_t             out_item_next;
    logic                  out_valid_reg;
    logic                  out_space;
    logic                  load_job;
    logic                  load_out;

    logic [SB-2:0]         sine_rom [QLEN+1];
    logic [TB-1:0]         idx;
    logic [TB-2:0]         rom_addr;
    logic [SB-1:0]         f;
    logic [SB:0]           f_ext;
    logic [SB:0]           tri_c;
    logic [SB:0]           tri_c2;
    logic [P2_W-1:0]       p2;
    logic [OUT_BITS-1:0]   q;

    // Quarter-wave sine table, built at elaboration
    for (genvar k = 0; k <= QLEN; k++)
    begin : g_rom
        assign sine_rom[k] = (SB - 1)'(mwo_quarter_sine(k, TB, SB));
    end

    assign out_space = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:    if (q_not_empty) state_next = BK_LOOKUP;
            BK_LOOKUP:  state_next = BK_SHAPE;
            BK_SHAPE:   state_next = BK_MUL_ENV;
            BK_MUL_ENV: state_next = BK_MUL_LVL;
            BK_MUL_LVL: if (out_space) state_next = BK_IDLE;
            default:    state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        load_job = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE:    load_job = q_not_empty;
            BK_MUL_LVL: load_out = out_space;
            default:    ;
        endcase
    end

    assign q_pop = load_job;

    // Sine address: mirror odd quadrants
    assign idx      = ph_reg[PHASE_BITS-1 -: TB];
    assign rom_addr = idx[TB-2] ? (QLEN_A - {1'b0, idx[TB-3:0]}) : {1'b0, idx[TB-3:0]};

    // Top sample bits of the phase (shifted up if the phase is narrower)
    always_comb
    begin
        logic [PHASE_BITS+SB-1:0] wide;
        wide = {ph_reg, {SB{1'b0}}};
        f    = wide[PHASE_BITS+SB-1 -: SB];
    end

    assign f_ext  = {1'b0, f};
    assign tri_c  = f[SB-1] ? (f_ext - HALF) : (HALF - f_ext);
    assign tri_c2 = tri_c << 1;

    // Waveform value as sign and magnitude
    always_comb
    begin
        neg_next = 1'b0;
        mag_next = '0;
        case (job_reg.waveform)
            WAVE_SINE:
            begin
                neg_next = idx[TB-1];
                mag_next = {1'b0, rom_q_reg};
            end
            WAVE_SAW:
            begin
                if (f_ext <= HALF)
                    mag_next = SB'(HALF - f_ext);
                else
                begin
                    neg_next = 1'b1;
                    mag_next = SB'(f_ext - HALF);
                end
            end
            WAVE_SQUARE:
            begin
                neg_next = ph_reg[PHASE_BITS-1] && (ph_reg[PHASE_BITS-2:0] != '0);
                mag_next = SB'(HALF);
            end
            WAVE_TRIANGLE:
            begin
                if (tri_c2 >= HALF)
                    mag_next = SB'(tri_c2 - HALF);
                else
                begin
                    neg_next = 1'b1;
                    mag_next = SB'(HALF - tri_c2);
                end
            end
            default: ;
        endcase
    end

    // Level multiply, truncate and saturate
    assign p2 = p1_reg * P2_W'(level);
    assign q  = p2[P2_W-1 -: OUT_BITS];

    always_comb
    begin
        out_item_next.block_end_out = job_reg.block_end;
        if (neg_reg)
            out_item_next.sample_out = (q > 16'd32768) ? SAT_NEG : $signed(-q);
        else
            out_item_next.sample_out = q[OUT_BITS-1] ? SAT_POS : $signed(q);
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (load_job)
        begin
            ph_reg  <= q_phase;
            job_reg <= q_job;
        end
        if (state_reg == BK_LOOKUP)
            rom_q_reg <= sine_rom[rom_addr];
        if (state_reg == BK_SHAPE)
        begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
        if (state_reg == BK_MUL_ENV)
            p1_reg <= P1_W'(mag_reg) * P1_W'(job_reg.envelope);
        if (load_out)
            out_item_reg <= out_item_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the multi-waveform phase-accumulator oscillator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwo_pkg::*;

    // Codes the package does not name
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED   = 2'd3;
    localparam logic [WAVE_BITS-1:0]    WAVE_UNK_LO  = 3'd5;
    localparam logic [WAVE_BITS-1:0]    WAVE_UNK_HI  = 3'd7;

    localparam int     QUARTER_LEN   = 256;
    localparam longint HALF_SCALE    = 32768;
    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     RANDOM_PHASES = 20;
    localparam int     QUIET_PHASES  = 3;
    localparam int     TONES_PER_SET = 75;
    localparam int     DIRECTED_ROWS = 44;

    typedef enum bit {ROW_WRITE, ROW_TONE} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_IDX_BITS-1:0]   idx;
        logic [CFG_DATA_BITS-1:0]  data;
        logic [GAIN_BITS-1:0]      env;
        logic                      be;
        bit                        has_lit;
        logic signed [OUT_BITS-1:0] lit;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    in_item_t                  in_item;
    logic                      out_valid;
    logic                      out_ready;
    out_item_t                 out_item;
    logic                      cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // Predictor state and register copies
    logic [STEP_BITS-1:0] osc_phase;
    logic [STEP_BITS-1:0] osc_step;
    logic [GAIN_BITS-1:0] osc_level;
    logic [WAVE_BITS-1:0] osc_wave;
    int                   quarter_wave [QUARTER_LEN+1];

    out_item_t expected_samples [$];
    out_item_t expected_head;
    int        mismatch_count;
    int        sent_count;
    int        checked_count;
    int        write_count;
    int        cycle_count;
    bit        quiet;

    // Directed table: literal results only where obvious
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b1, 1'b1, 16'sd0},
        '{ROW_WRITE, REG_LEVEL, 32'h0000_FFFF, 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_WAVEFORM, 32'(WAVE_SQUARE), 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b0, 1'b1, 16'sd32767},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'h0000, 1'b1, 1'b1, 16'sd0},
        '{ROW_WRITE, REG_WAVEFORM, 32'(WAVE_SAW), 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b0, 1'b1, 16'sd32767},
        '{ROW_WRITE, REG_WAVEFORM, 32'(WAVE_TRIANGLE), 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b1, 1'b1, 16'sd32767},
        '{ROW_WRITE, REG_WAVEFORM, 32'(WAVE_SILENT), 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b0, 1'b1, 16'sd0},
        '{ROW_WRITE, REG_WAVEFORM, 32'(WAVE_UNK_LO), 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b1, 1'b1, 16'sd0},
        '{ROW_WRITE, REG_WAVEFORM, {29'h1FFF_FFFF, WAVE_UNK_HI}, 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'h8000, 1'b0, 1'b1, 16'sd0},
        '{ROW_WRITE, REG_UNUSED, 32'hDEAD_BEEF, 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_WAVEFORM, {29'h1FFF_FFFF, WAVE_SINE}, 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_LEVEL, 32'h0000_0000, 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b1, 1'b1, 16'sd0},
        '{ROW_WRITE, REG_LEVEL, 32'hABCD_FFFF, 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_PHASE_STEP, 32'h8000_0000, 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b1, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_WAVEFORM, 32'(WAVE_TRIANGLE), 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b1, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_WAVEFORM, 32'(WAVE_SQUARE), 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b1, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_WAVEFORM, 32'(WAVE_SAW), 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b1, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_PHASE_STEP, 32'h4000_0000, 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_WAVEFORM, 32'(WAVE_SINE), 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'h1234, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'h8000, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b1, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_PHASE_STEP, 32'h0000_0001, 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'h0001, 1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_PHASE_STEP, 32'h8000_0000, 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, REG_WAVEFORM, 32'(WAVE_SQUARE), 16'd0, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b0, 1'b0, 16'sd0},
        '{ROW_TONE,  REG_PHASE_STEP, 32'd0, 16'hFFFF, 1'b1, 1'b0, 16'sd0}
    };

    multi_waveform_oscillator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Quarter-wave sine table, same Q30 Taylor evaluation as the design
    initial
    begin : build_quarter
        logic [63:0] amp;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        amp = 64'(HALF_SCALE - 1);
        for (int k = 0; k <= QUARTER_LEN; k++)
        begin
            x  = (64'(k) * HALF_PI_Q30) >> 8;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (int i = 0; i < 6; i++)
                t = ONE_Q30 - (((x2 * t) >> 30) / TAYLOR_DIV[i]);
            s = (x * t) >> 30;
            v = (s * amp + (64'd1 << 29)) >> 30;
            if (v > amp)
                v = amp;
            quarter_wave[k] = int'(v);
        end
    end

    // Next sample for one envelope value; advances the predicted phase
    function automatic out_item_t osc_predict(input logic [GAIN_BITS-1:0] env,
                                              input logic be);
        logic [9:0] idx;
        longint     frac;
        longint     wave_val;
        longint     mag;
        longint     prod;
        bit         neg;
        out_item_t  res;
        frac           = longint'(osc_phase[31:16]);
        wave_val       = 0;
        res.sample_out = '0;
        if (osc_wave >= WAVE_SINE && osc_wave <= WAVE_TRIANGLE)
        begin
            case (osc_wave)
                WAVE_SINE:
                begin
                    idx = osc_phase[31:22];
                    // odd quadrants read the table mirrored, upper half negated
                    if (idx[8])
                        wave_val = quarter_wave[QUARTER_LEN - int'(idx[7:0])];
                    else
                        wave_val = quarter_wave[int'(idx[7:0])];
                    if (idx[9])
                        wave_val = -wave_val;
                end
                WAVE_SAW:
                    wave_val = HALF_SCALE - frac;
                WAVE_SQUARE:
                    wave_val = (osc_phase <= 32'h8000_0000) ? HALF_SCALE : -HALF_SCALE;
                default:
                begin
                    wave_val = frac - HALF_SCALE;
                    if (wave_val < 0)
                        wave_val = -wave_val;
                    wave_val = 2 * wave_val - HALF_SCALE;
                end
            endcase
            // magnitude scaling, truncation toward zero, then saturation
            neg  = wave_val < 0;
            mag  = neg ? -wave_val : wave_val;
            prod = (mag * longint'(env) * longint'(osc_level)) >> 32;
            if (neg)
                res.sample_out = (prod > 32768) ? -16'sd32768 : 16'(-prod);
            else
                res.sample_out = (prod > 32767) ? 16'sd32767 : 16'(prod);
            osc_phase = osc_phase + osc_step;
        end
        res.block_end_out = be;
        return res;
    endfunction

    // Register write once every expected sample has come back
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_PHASE_STEP: osc_step  = data;
            REG_LEVEL:      osc_level = data[GAIN_BITS-1:0];
            REG_WAVEFORM:   osc_wave  = data[WAVE_BITS-1:0];
            default: ;
        endcase
        write_count++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_data  <= $urandom;
    endtask

    // One input transaction, then maybe an idle burst
    task automatic send_tone(input logic [GAIN_BITS-1:0] env, input logic be,
                             input bit has_lit, input logic signed [OUT_BITS-1:0] lit);
        out_item_t pred;
        @(negedge clk);
        in_valid          <= 1'b1;
        in_item.envelope  <= env;
        in_item.block_end <= be;
        do
            @(posedge clk);
        while (!in_ready);
        pred = osc_predict(env, be);
        if (has_lit)
            pred.sample_out = lit;
        expected_samples.insert(expected_samples.size(), pred);
        sent_count++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            in_item  <= in_item_t'($urandom);
            repeat ($urandom_range(0, 13)) @(negedge clk);
        end
    endtask

    // Receiver: random stall bursts, none in the quiet stretch
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Output checker: compare each transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected output sample %0d block_end %0b", $realtime,
                         out_item.sample_out, out_item.block_end_out);
                mismatch_count++;
            end
            else
            begin
                expected_head = expected_samples.pop_front();
                checked_count++;
                if (out_item.sample_out !== expected_head.sample_out)
                begin
                    $display("%0t: sample_out expected %0d actual %0d", $realtime,
                             expected_head.sample_out, out_item.sample_out);
                    mismatch_count++;
                end
                if (out_item.block_end_out !== expected_head.block_end_out)
                begin
                    $display("%0t: block_end_out expected %0b actual %0b", $realtime,
                             expected_head.block_end_out, out_item.block_end_out);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Main sequence
    initial
    begin : main_seq
        logic [CFG_DATA_BITS-1:0] rnd;
        logic [WAVE_BITS-1:0]     wave_pick;
        logic [GAIN_BITS-1:0]     level_pick;
        logic [STEP_BITS-1:0]     step_pick;
        logic [GAIN_BITS-1:0]     env_pick;
        int                       drain_guard;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        quiet          = 1'b0;
        mismatch_count = 0;
        sent_count     = 0;
        checked_count  = 0;
        write_count    = 0;
        cycle_count    = 0;
        osc_phase      = '0;
        osc_step       = PHASE_STEP_RST;
        osc_level      = LEVEL_RST;
        osc_wave       = WAVEFORM_RST;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            else
                send_tone(directed_rows[r].env, directed_rows[r].be,
                          directed_rows[r].has_lit, directed_rows[r].lit);
        end

        // Random register settings, each followed by a burst of tones
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph >= RANDOM_PHASES - QUIET_PHASES)
                quiet = 1'b1;

            case ($urandom_range(0, 5))
                0:       step_pick = 32'h8000_0000;
                1:       step_pick = $urandom_range(0, 1) ? 32'd0 : 32'd1;
                2:       step_pick = $urandom_range(0, 32'h8000_0000);
                default: step_pick = $urandom_range(0, 32'h0010_0000);
            endcase
            case ($urandom_range(0, 4))
                0:       level_pick = 16'hFFFF;
                1:       level_pick = $urandom_range(0, 1) ? 16'h0000 : LEVEL_RST;
                default: level_pick = 16'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       wave_pick = WAVE_SILENT;
                1:       wave_pick = 3'($urandom_range(WAVE_UNK_LO, WAVE_UNK_HI));
                default: wave_pick = 3'($urandom_range(WAVE_SINE, WAVE_TRIANGLE));
            endcase

            rnd = $urandom;
            write_reg(REG_PHASE_STEP, step_pick);
            write_reg(REG_LEVEL, {rnd[31:16], level_pick});
            rnd = $urandom;
            write_reg(REG_WAVEFORM, {rnd[31:3], wave_pick});
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_UNUSED, $urandom);

            for (int n = 0; n < TONES_PER_SET; n++)
            begin
                case ($urandom_range(0, 9))
                    0:       env_pick = 16'h0000;
                    1:       env_pick = 16'hFFFF;
                    default: env_pick = 16'($urandom);
                endcase
                send_tone(env_pick, ($urandom_range(0, 7) == 0), 1'b0, 16'sd0);
            end
        end

        // Drain and let the pipeline settle
        @(negedge clk);
        in_valid    <= 1'b0;
        drain_guard = 0;
        while (expected_samples.size() != 0 && drain_guard < 10000)
        begin
            @(posedge clk);
            drain_guard++;
        end
        repeat (20) @(posedge clk);
        if (expected_samples.size() != 0)
        begin
            $display("%0t: %0d expected samples never arrived", $realtime,
                     expected_samples.size());
            mismatch_count++;
        end

        $display("Ran %0d tone transactions over %0d register writes (all waveforms).",
                 sent_count, write_count);
        $display("Compared %0d output samples; %0d mismatches.", checked_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
